// ===== rtl/core/sph_density_summation_core_macros.svh =====
// Assertion macros shared by the density summation core.
// Expects clk and rst_n in the scope of every use.
`ifndef SPH_DENSITY_SUMMATION_CORE_MACROS_SVH
`define SPH_DENSITY_SUMMATION_CORE_MACROS_SVH

// same-cycle implication
`define SPH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sph_pkg.sv =====
// Package for the density summation core: field widths, defaults, command type.
// No dependencies.
package sph_pkg;

    localparam int MAX_PARTICLES_DEF = 64;

    localparam int POS_W     = 24;
    localparam int MASS_W    = 16;
    localparam int RADIUS_W  = 20;
    localparam int SCALE_W   = 48;
    localparam int DENSITY_W = 32;
    localparam int PIDX_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 48;
    localparam int ENTRY_W   = 2 * POS_W + MASS_W;

    // wide enough for a particle count up to 1024
    localparam int CMD_CNT_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SCALE = 1'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 20'd16384;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 48'd538500000;

    typedef struct packed {
        logic [CMD_CNT_W-1:0] count;
    } cmd_t;

endpackage

// ===== rtl/core/sph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sph_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sph_front.sv =====
// Front end: accepts particle transactions, writes the store, queues a run.
// Depends on sph_pkg.
module sph_front #(
    parameter int MAX_PARTICLES = sph_pkg::MAX_PARTICLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [sph_pkg::POS_W-1:0]    pos_x,
    input  logic signed [sph_pkg::POS_W-1:0]    pos_y,
    input  logic [sph_pkg::MASS_W-1:0]          mass,
    input  logic                                last_particle,
    output logic                                ram_we,
    output logic [$clog2(MAX_PARTICLES)-1:0]    ram_waddr,
    output logic [sph_pkg::ENTRY_W-1:0]         ram_wdata,
    output logic                                cmd_push,
    output sph_pkg::cmd_t                       cmd
);
    import sph_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = IDX_W + 1;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;
    logic             accept;
    logic             full;

    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_W'(MAX_PARTICLES));
    assign count_inc = full ? count_reg : count_reg + CNT_W'(1);

    // a full store drops the data but the last mark still starts the run
    assign ram_we    = accept && !full;
    assign ram_waddr = count_reg[IDX_W-1:0];
    assign ram_wdata = {pos_x, pos_y, mass};

    assign cmd_push  = accept && last_particle;
    assign cmd.count = CMD_CNT_W'(count_inc);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = last_particle ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/sph_cmd_queue.sv =====
// Two-entry queue of run commands between front and back end.
// Depends on sph_pkg.
module sph_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sph_pkg::cmd_t cmd_in,
    input  logic          pop,
    output sph_pkg::cmd_t cmd_out,
    output logic          empty
);
    import sph_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign empty   = (fill_reg == 2'd0);
    assign do_pop  = pop && !empty;
    assign do_push = push && (fill_reg != 2'd2);
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// ===== rtl/core/sph_back.sv =====
// Back end: row/column sequencer, pair pipeline, accumulator and scaling.
// Depends on sph_pkg and sph_density_summation_core_macros.svh.
`include "sph_density_summation_core_macros.svh"

module sph_back #(
    parameter int MAX_PARTICLES = sph_pkg::MAX_PARTICLES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_empty,
    input  sph_pkg::cmd_t                        cmd,
    output logic                                 cmd_pop,
    output logic [$clog2(MAX_PARTICLES)-1:0]     ram_raddr,
    input  logic [sph_pkg::ENTRY_W-1:0]          ram_rdata,
    input  logic [sph_pkg::RADIUS_W-1:0]         radius,
    input  logic [sph_pkg::SCALE_W-1:0]          kernel_scale,
    output logic                                 active,
    output logic                                 result_valid,
    output logic [sph_pkg::DENSITY_W-1:0]        density,
    output logic [sph_pkg::PIDX_W-1:0]           particle_index,
    output logic                                 last_density
);
    import sph_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROW_RD = 3'd1;
    localparam logic [2:0] ST_ROW_LT = 3'd2;
    localparam logic [2:0] ST_PAIR   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_SCALE1 = 3'd5;
    localparam logic [2:0] ST_SCALE2 = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;
    logic             row_last;
    logic             col_last;

    logic signed [POS_W-1:0] xi_reg;
    logic signed [POS_W-1:0] yi_reg;
    logic [2*RADIUS_W-1:0]   h2_reg;

    // pipeline: s0 read, s1 squares, s2 t, s3 t^2 and t*m, s4 partials, s5 term
    logic              s0_v_reg, s0_self_reg;
    logic              s1_v_reg, s1_self_reg;
    logic [47:0]       s1_sqx_reg, s1_sqy_reg;
    logic [MASS_W-1:0] s1_m_reg;
    logic              s2_v_reg;
    logic [27:0]       s2_t_reg;
    logic [MASS_W-1:0] s2_m_reg;
    logic              s3_v_reg;
    logic [55:0]       s3_tt_reg;
    logic [43:0]       s3_tm_reg;
    logic              s4_v_reg;
    logic [49:0]       s4_p00_reg, s4_p01_reg, s4_p10_reg, s4_p11_reg;
    logic              s5_v_reg;
    logic [63:0]       s5_term_reg;
    logic [63:0]       acc_reg;
    logic              pipe_busy;

    logic [63:0] q00_reg, q10_reg;
    logic [47:0] q01_reg, q11_reg;

    logic                 valid_reg;
    logic [DENSITY_W-1:0] density_reg;
    logic [IDX_W+PIDX_W-1:0] pidx_reg;
    logic                 last_reg;

    logic signed [POS_W:0]     dx, dy;
    logic signed [2*POS_W+1:0] sqx, sqy;
    logic [POS_W-1:0]          xj, yj;
    logic [MASS_W-1:0]         mj;
    logic [48:0]               d2;
    logic [48:0]               h2_ext;
    logic [48:0]               diff;
    logic [99:0]               prod;
    logic [64:0]               acc_sum;
    logic [111:0]              sprod;

    assign row_last  = ({1'b0, row_reg} == n_reg - CNT_W'(1));
    assign col_last  = ({1'b0, col_reg} == n_reg - CNT_W'(1));
    assign pipe_busy = s0_v_reg | s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg | s5_v_reg;
    assign active    = (state_reg != ST_IDLE);
    assign cmd_pop   = (state_reg == ST_IDLE) && !cmd_empty;
    assign ram_raddr = (state_reg == ST_PAIR) ? col_reg : row_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (!cmd_empty) state_next = ST_ROW_RD;
            ST_ROW_RD: state_next = ST_ROW_LT;
            ST_ROW_LT: state_next = ST_PAIR;
            ST_PAIR:   if (col_last) state_next = ST_DRAIN;
            ST_DRAIN:  if (!pipe_busy) state_next = ST_SCALE1;
            ST_SCALE1: state_next = ST_SCALE2;
            ST_SCALE2: state_next = row_last ? ST_IDLE : ST_ROW_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    // stage arithmetic
    assign xj     = ram_rdata[ENTRY_W-1 -: POS_W];
    assign yj     = ram_rdata[MASS_W +: POS_W];
    assign mj     = ram_rdata[MASS_W-1:0];
    assign dx     = $signed({xi_reg[POS_W-1], xi_reg}) - $signed({xj[POS_W-1], xj});
    assign dy     = $signed({yi_reg[POS_W-1], yi_reg}) - $signed({yj[POS_W-1], yj});
    assign sqx    = dx * dx;
    assign sqy    = dy * dy;
    assign d2     = {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};
    assign h2_ext = {9'd0, h2_reg};
    assign diff   = h2_ext - d2;
    assign prod   = {50'd0, s4_p00_reg}
                  + {28'd0, s4_p01_reg, 22'd0}
                  + {22'd0, s4_p10_reg, 28'd0}
                  + {s4_p11_reg, 50'd0};
    assign acc_sum = {1'b0, acc_reg} + {1'b0, s5_term_reg};
    assign sprod  = {48'd0, q00_reg}
                  + {32'd0, q01_reg, 32'd0}
                  + {16'd0, q10_reg, 32'd0}
                  + {q11_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        h2_reg <= radius * radius;
        if (state_reg == ST_ROW_LT)
        begin
            xi_reg <= xj;
            yi_reg <= yj;
        end
        s1_sqx_reg  <= sqx[47:0];
        s1_sqy_reg  <= sqy[47:0];
        s1_m_reg    <= mj;
        s1_self_reg <= s0_self_reg;
        // out of range or self pair contributes zero
        s2_t_reg    <= (s1_self_reg || d2 >= h2_ext) ? 28'd0 : diff[39:12];
        s2_m_reg    <= s1_m_reg;
        s3_tt_reg   <= s2_t_reg * s2_t_reg;
        s3_tm_reg   <= s2_t_reg * {12'd0, s2_m_reg};
        s4_p00_reg  <= s3_tt_reg[27:0]  * s3_tm_reg[21:0];
        s4_p01_reg  <= s3_tt_reg[27:0]  * s3_tm_reg[43:22];
        s4_p10_reg  <= s3_tt_reg[55:28] * s3_tm_reg[21:0];
        s4_p11_reg  <= s3_tt_reg[55:28] * s3_tm_reg[43:22];
        s5_term_reg <= (prod[99:84] != 16'd0) ? {64{1'b1}} : prod[83:20];
        q00_reg     <= acc_reg[31:0]  * kernel_scale[31:0];
        q01_reg     <= acc_reg[31:0]  * kernel_scale[47:32];
        q10_reg     <= acc_reg[63:32] * kernel_scale[31:0];
        q11_reg     <= acc_reg[63:32] * kernel_scale[47:32];
        if (state_reg == ST_SCALE2)
        begin
            density_reg <= (sprod[111:96] != 16'd0) ? {DENSITY_W{1'b1}} : sprod[95:64];
            pidx_reg    <= {{PIDX_W{1'b0}}, row_reg};
            last_reg    <= row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            s0_v_reg    <= 1'b0;
            s0_self_reg <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            s5_v_reg    <= 1'b0;
            acc_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            s0_v_reg    <= (state_reg == ST_PAIR);
            s0_self_reg <= (col_reg == row_reg);
            s1_v_reg    <= s0_v_reg;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            s5_v_reg    <= s4_v_reg;
            valid_reg   <= (state_reg == ST_SCALE2);
            case (state_reg)
                ST_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        n_reg   <= cmd.count[CNT_W-1:0];
                        row_reg <= '0;
                    end
                end
                ST_ROW_LT:
                begin
                    col_reg <= '0;
                    acc_reg <= '0;
                end
                ST_PAIR:
                begin
                    col_reg <= col_reg + IDX_W'(1);
                end
                ST_SCALE2:
                begin
                    row_reg <= row_reg + IDX_W'(1);
                end
                default:
                begin
                end
            endcase
            if (s5_v_reg)
            begin
                acc_reg <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
            end
        end
    end

    assign result_valid   = valid_reg;
    assign density        = density_reg;
    assign particle_index = pidx_reg[PIDX_W-1:0];
    assign last_density   = last_reg;

    `SPH_ASSERT_IMP(a_col_in_range, state_reg == ST_PAIR, {1'b0, col_reg} < n_reg, "column beyond count")
    `SPH_ASSERT_IMP(a_row_in_range, state_reg == ST_SCALE2, {1'b0, row_reg} < n_reg, "row beyond count")
    `SPH_ASSERT_IMP(a_last_idle, valid_reg && last_reg, state_reg == ST_IDLE, "run continues after last")

endmodule

// ===== rtl/core/sph_density_summation_core.sv =====
// Top level of the SPH density summation core.
// Depends on sph_pkg, sph_ram, sph_front, sph_cmd_queue, sph_back.
//
// Usage:
//   Particles are loaded one per transaction: a transaction is taken at a
//   rising edge with start high and busy low, carrying pos_x, pos_y (Q12.12)
//   and mass (Q8.8). Loading runs at one particle per cycle while busy is
//   low. Particles past MAX_PARTICLES are dropped. A transaction with
//   last_particle set starts the run; busy rises the next cycle and stays
//   high until the final density has been issued.
//   Results: one density per stored particle in load order, each shown for
//   exactly one cycle with result_valid high, carrying particle_index and
//   last_density on the final one. The receiver cannot stall.
//   Sequencing: each row (one particle) first reads its own entry, then
//   pairs it with every stored particle (one pair per cycle through a single
//   read port of the store), then drains the pipeline and scales the sum.
//   Configuration: cfg_we writes radius (index 0) or kernel_scale (index 1)
//   from cfg_data; write only while idle.
//   Reset: clears the load count, command queue and sequencer; the
//   particle store itself is not cleared and only loaded entries are read.
module sph_density_summation_core #(
    parameter int MAX_PARTICLES = sph_pkg::MAX_PARTICLES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [sph_pkg::POS_W-1:0]     pos_x,
    input  logic signed [sph_pkg::POS_W-1:0]     pos_y,
    input  logic [sph_pkg::MASS_W-1:0]           mass,
    input  logic                                 last_particle,
    input  logic                                 cfg_we,
    input  logic [sph_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sph_pkg::CFG_W-1:0]            cfg_data,
    output logic                                 result_valid,
    output logic [sph_pkg::DENSITY_W-1:0]        density,
    output logic [sph_pkg::PIDX_W-1:0]           particle_index,
    output logic                                 last_density
);
    import sph_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);

    logic [RADIUS_W-1:0] radius_reg;
    logic [SCALE_W-1:0]  scale_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               cmd_push;
    logic               cmd_pop;
    logic               cmd_empty;
    cmd_t               cmd_in;
    cmd_t               cmd_out;
    logic               back_active;

    // busy covers a queued run and the run in progress
    assign busy = !cmd_empty || back_active;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            scale_reg  <= SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS:       radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_KERNEL_SCALE: scale_reg  <= cfg_data[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // particle store: {x, y, mass} per entry
    sph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sph_front #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .mass          (mass),
        .last_particle (last_particle),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in)
    );

    sph_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .cmd_in  (cmd_in),
        .pop     (cmd_pop),
        .cmd_out (cmd_out),
        .empty   (cmd_empty)
    );

    sph_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_empty      (cmd_empty),
        .cmd            (cmd_out),
        .cmd_pop        (cmd_pop),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .radius         (radius_reg),
        .kernel_scale   (scale_reg),
        .active         (back_active),
        .result_valid   (result_valid),
        .density        (density),
        .particle_index (particle_index),
        .last_density   (last_density)
    );

endmodule
